[rtl/arsl_pkg.sv]
// ----------------------------------------------------------------------------
// Address region slot table package
// Item types, operation and status codes, and the command and status groups
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package arsl_pkg;

  localparam int DEF_NUM_SLOTS = 64;
  localparam int DEF_ADDR_BITS = 48;

  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 48;
  localparam int LEN_W    = 32;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  region_length;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_index;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic                take_item;
    logic                inc_cnt;
    logic                alloc_write;
    logic                free_clear;
    logic                load_out;
    logic [STATUS_W-1:0] out_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic slot_active;
    logic match;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/arsl_dp.sv]
// ----------------------------------------------------------------------------
// Address region slot table datapath
// Holds the active bits, the region memory, the scan counter, the range
// compare and the result register.
// ----------------------------------------------------------------------------
module arsl_dp #(
  parameter int NUM_SLOTS = 64,
  parameter int ADDR_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  arsl_pkg::req_t     req,
  input  arsl_pkg::ctl_cmd_t cmd,
  output arsl_pkg::dp_stat_t stat,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output arsl_pkg::rsp_t     rsp
);
  import arsl_pkg::*;

  localparam int IDX_W   = $clog2(NUM_SLOTS);
  localparam int ENTRY_W = ADDR_BITS + LEN_W;
  localparam int CMP_W   = (ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W;
  localparam int EXT_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  logic [KIND_W-1:0]    kind;
  logic [ADDR_BITS-1:0] addr;
  logic [LEN_W-1:0]     len;
  logic [IDX_W-1:0]     cnt;
  logic [NUM_SLOTS-1:0] active;
  logic [ENTRY_W-1:0]   mem [NUM_SLOTS];
  logic [ENTRY_W-1:0]   rd_entry;
  logic [ADDR_BITS-1:0] rd_base;
  logic [LEN_W-1:0]     rd_len;
  logic [CMP_W-1:0]     diff;
  logic                 in_range;
  logic [EXT_W-1:0]     idx_ext;
  rsp_t                 rsp_next;
  logic                 out_valid;
  rsp_t                 out_reg;

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      kind <= req.kind;
      addr <= ADDR_BITS'(req.address);
      len  <= req.region_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.take_item) begin
      cnt <= '0;
    end else if (cmd.inc_cnt) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.alloc_write) begin
      active[cnt] <= 1'b1;
    end else if (cmd.free_clear) begin
      active[cnt] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_write) begin
      mem[cnt] <= {addr, len};
    end
    rd_entry <= mem[cnt];
  end

  assign rd_base  = rd_entry[ENTRY_W-1:LEN_W];
  assign rd_len   = rd_entry[LEN_W-1:0];
  assign diff     = CMP_W'(addr) - CMP_W'(rd_base);
  assign in_range = (rd_len == '0) ? (addr == rd_base)
                                   : ((addr >= rd_base) && (diff < CMP_W'(rd_len)));

  assign stat.is_alloc    = (kind == KIND_ALLOC);
  assign stat.is_free     = (kind == KIND_FREE);
  assign stat.slot_active = active[cnt];
  assign stat.match       = in_range;
  assign stat.last        = (cnt == IDX_W'(NUM_SLOTS - 1));
  assign stat.out_free    = !out_valid || rsp_ready;

  assign idx_ext = EXT_W'(cnt);

  always_comb begin
    rsp_next.status     = cmd.out_status;
    rsp_next.slot_index = (cmd.out_status == STATUS_OK) ? idx_ext[SLOT_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_reg <= rsp_next;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_reg;

endmodule

[rtl/arsl_ctrl.sv]
// ----------------------------------------------------------------------------
// Address region slot table controller
// Steps the slot scan for each item and decides when and how it ends.
// ----------------------------------------------------------------------------
module arsl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  arsl_pkg::dp_stat_t stat,
  output arsl_pkg::ctl_cmd_t cmd
);
  import arsl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.is_alloc) begin
          if ((!stat.slot_active || stat.last) && stat.out_free) begin
            state_next = ST_IDLE;
          end
        end else if (stat.slot_active) begin
          state_next = ST_CHECK;
        end else if (stat.last && stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (stat.match || stat.last) begin
          if (stat.out_free) begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_status = STATUS_OK;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready     = 1'b1;
        cmd.take_item = req_valid;
      end
      ST_SCAN: begin
        if (stat.is_alloc) begin
          if (!stat.slot_active) begin
            cmd.alloc_write = stat.out_free;
            cmd.load_out    = stat.out_free;
          end else if (stat.last) begin
            cmd.out_status = STATUS_FULL;
            cmd.load_out   = stat.out_free;
          end else begin
            cmd.inc_cnt = 1'b1;
          end
        end else if (!stat.slot_active) begin
          if (stat.last) begin
            cmd.out_status = STATUS_MISSING;
            cmd.load_out   = stat.out_free;
          end else begin
            cmd.inc_cnt = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (stat.match) begin
          cmd.free_clear = stat.is_free && stat.out_free;
          cmd.load_out   = stat.out_free;
        end else if (stat.last) begin
          cmd.out_status = STATUS_MISSING;
          cmd.load_out   = stat.out_free;
        end else begin
          cmd.inc_cnt = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/address_region_slot_table.sv]
// ----------------------------------------------------------------------------
// Address region slot table
// A table of address regions with allocate, free and lookup by address.
// ----------------------------------------------------------------------------
// Each item is handled on its own by a scan over the slots, lowest first. The
// item is taken in the idle state; the scan state passes each free slot, and
// a lookup or free compares each active slot in the check state after it,
// because the region memory has a registered read port. An allocate ends at
// the first free slot, or as full at the last slot. A lookup or free ends at
// the first match, or as missing at the last slot. The next item is taken
// while the previous result waits in the output register; a result that
// cannot be placed holds the scan until the output side takes that result.
module address_region_slot_table #(
  parameter int NUM_SLOTS = arsl_pkg::DEF_NUM_SLOTS,
  parameter int ADDR_BITS = arsl_pkg::DEF_ADDR_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  arsl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output arsl_pkg::rsp_t rsp
);
  import arsl_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  arsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  arsl_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
